### sv/wdmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdmm_pkg: shared types and constants
// Widths of the sample and period words and the control struct for the
// running min/max unit.
// ----------------------------------------------------------------------------
package wdmm_pkg;

	localparam int SAMPLE_W = 10;
	localparam int PERIOD_W = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [PERIOD_W-1:0] period_t;

	typedef struct packed {
		logic clear;   // start a new scan
		logic en;      // fold one ring entry into the running marks
	} mm_ctl_t;

endpackage
`default_nettype wire

### sv/wdmm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdmm_cell: one ring entry
// Holds one past sample and passes it on to the next cell when enabled.
// ----------------------------------------------------------------------------
module wdmm_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wdmm_pkg::sample_t   din,
	output wdmm_pkg::sample_t   dout
);

	wdmm_pkg::sample_t val_q;

	// ring starts as zeros; they count in the marks until overwritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (en) begin
			val_q <= din;
		end
	end

	assign dout = val_q;

endmodule
`default_nettype wire

### sv/wdmm_minmax.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdmm_minmax: running window marks
// Folds one entry per cycle into the low and high marks while ctl.en is set. Between scans the
// registers hold the marks of the last completed window.
// ----------------------------------------------------------------------------
module wdmm_minmax (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wdmm_pkg::mm_ctl_t   ctl,
	input  wdmm_pkg::sample_t   value,
	output wdmm_pkg::sample_t   low,
	output wdmm_pkg::sample_t   high
);

	wdmm_pkg::sample_t low_q;
	wdmm_pkg::sample_t high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (ctl.clear) begin
			low_q  <= '1;
			high_q <= '0;
		end else if (ctl.en) begin
			if (value < low_q) begin
				low_q <= value;
			end
			if (value > high_q) begin
				high_q <= value;
			end
		end
	end

	assign low  = low_q;
	assign high = high_q;

endmodule
`default_nettype wire

### sv/decimated_window_min_max_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimated_window_min_max_top: decimated sliding-window min/max
// Prescaled sampling of ADC words into a ring of cells, with min/max of the
// ring recomputed by rotating the ring past a running min/max unit.
// ----------------------------------------------------------------------------
// Latency: a tick that takes no sample has its result word in the cycle after
//   accept; a tick that takes a sample passes through the scan state (one
//   rotation of the cell ring through the min/max unit), then the finish state.
// Throughput: one word per cycle for non-sampling ticks while out_stall is low;
//   a sampling tick stalls the input until the scan and finish states are done.
// Reset: asynchronous; ring cells, marks, counter and period go to zero.
module decimated_window_min_max_top #(
	parameter int RING_DEPTH = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration
	input  wire                 cfg_we,
	input  wdmm_pkg::period_t   cfg_wdata,
	// input words
	input  wire                 in_valid,
	output logic                in_stall,
	input  wdmm_pkg::sample_t   adc_sample,
	// result words
	output logic                out_valid,
	input  wire                 out_stall,
	output logic                sampled,
	output wdmm_pkg::sample_t   sample_out,
	output wdmm_pkg::sample_t   window_min,
	output wdmm_pkg::sample_t   window_max
);

	localparam int CNT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	wdmm_pkg::period_t   period_q;
	wdmm_pkg::period_t   tick_q;
	wdmm_pkg::period_t   limit;
	wdmm_pkg::sample_t   sample_q;

	logic                out_valid_q;
	logic                sampled_q;
	wdmm_pkg::sample_t   sample_out_q;
	wdmm_pkg::sample_t   min_q;
	wdmm_pkg::sample_t   max_q;

	logic                in_acc;
	logic                out_acc;
	logic                taken;
	logic                ring_en;
	wdmm_pkg::mm_ctl_t   mm_ctl;
	wdmm_pkg::sample_t   mm_low;
	wdmm_pkg::sample_t   mm_high;
	wdmm_pkg::sample_t   tail;

	wdmm_pkg::sample_t   cell_d [RING_DEPTH];
	wdmm_pkg::sample_t   cell_q [RING_DEPTH];

	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign limit = (period_q == '0) ? '0 : period_q - 1'b1;
	assign taken = (tick_q >= limit);

	// cell ring: a new sample enters at cell 0; during a scan the ring
	// rotates once so the tail passes every entry through the min/max unit
	assign tail    = cell_q[RING_DEPTH-1];
	assign ring_en = (in_acc && taken) || (state_q == ST_SCAN);

	genvar gi;
	generate
		for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign cell_d[gi] = (state_q == ST_IDLE) ? adc_sample : tail;
			end else begin : g_body
				assign cell_d[gi] = cell_q[gi-1];
			end
			wdmm_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (ring_en),
				.din   (cell_d[gi]),
				.dout  (cell_q[gi])
			);
		end
	endgenerate

	assign mm_ctl.clear = in_acc && taken;
	assign mm_ctl.en    = (state_q == ST_SCAN);

	wdmm_minmax u_minmax (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mm_ctl),
		.value (tail),
		.low   (mm_low),
		.high  (mm_high)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tick_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (taken) begin
							tick_q  <= '0;
							cnt_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							tick_q <= tick_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(RING_DEPTH - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && taken) begin
			sample_q <= adc_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && !taken) || (state_q == ST_FIN)) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (in_acc && !taken) begin
			sampled_q    <= 1'b0;
			sample_out_q <= '0;
			min_q        <= mm_low;
			max_q        <= mm_high;
		end else if (state_q == ST_FIN) begin
			sampled_q    <= 1'b1;
			sample_out_q <= sample_q;
			min_q        <= mm_low;
			max_q        <= mm_high;
		end
	end

	assign out_valid  = out_valid_q;
	assign sampled    = sampled_q;
	assign sample_out = sample_out_q;
	assign window_min = min_q;
	assign window_max = max_q;

	// after a full rotation the marks cover at least one real entry
	a_marks_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (mm_low <= mm_high))
		else $error("window marks out of order after scan");

	a_sample_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && taken) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("sampling tick did not start a scan");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while scanning");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN || (in_acc && !taken)))
		else $error("result word raised without a source");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!out_valid_q || !out_stall))
		else $error("scan finished while result word still pending");

endmodule
`default_nettype wire
